### rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg: shared definitions for the duration statistics accumulator
// Statistic codes, default widths, and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsa_pkg;

    // Default field widths
    localparam int TICK_WIDTH_DEF  = 48;
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed widths of the total and the reported statistic
    localparam int STAT_WIDTH = 64;

    // Divider sequencing: one quotient bit per step
    localparam int DIV_STEPS = STAT_WIDTH;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Input command codes
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Selected statistic
    typedef enum logic [1:0] {
        STAT_SUM = 2'd0,
        STAT_MIN = 2'd1,
        STAT_MAX = 2'd2,
        STAT_AVG = 2'd3
    } t_stat_mode;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // input word taken this cycle: update statistics
        logic div_start;  // launch total / count
        logic load_out;   // capture result word into output register
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_needed; // average selected and count is nonzero
        logic div_done;   // last divider step in this cycle
        logic out_free;   // output register can take a new word
    } t_dp_status;

endpackage

### rtl/dsa_in_if.sv
// ----------------------------------------------------------------------------
// dsa_in_if: input channel of the duration statistics accumulator
// Valid/ready channel carrying one command word with its duration.
// ----------------------------------------------------------------------------
interface dsa_in_if #(
    parameter int TICK_WIDTH = dsa_pkg::TICK_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [TICK_WIDTH-1:0] duration_ticks;

    modport source (output valid, output command, output duration_ticks, input ready);
    modport sink   (input valid, input command, input duration_ticks, output ready);
endinterface

### rtl/dsa_out_if.sv
// ----------------------------------------------------------------------------
// dsa_out_if: result channel of the duration statistics accumulator
// Valid/ready channel carrying the selected statistic and the summary fields.
// ----------------------------------------------------------------------------
interface dsa_out_if #(
    parameter int TICK_WIDTH  = dsa_pkg::TICK_WIDTH_DEF,
    parameter int COUNT_WIDTH = dsa_pkg::COUNT_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [dsa_pkg::STAT_WIDTH-1:0]  selected_stat;
    logic [TICK_WIDTH-1:0]           last_duration;
    logic [COUNT_WIDTH-1:0]          sample_count;
    logic                            no_samples;

    modport source (output valid, output selected_stat, output last_duration,
                    output sample_count, output no_samples, input ready);
    modport sink   (input valid, input selected_stat, input last_duration,
                    input sample_count, input no_samples, output ready);
endinterface

### rtl/dsa_divider.sv
// ----------------------------------------------------------------------------
// dsa_divider: radix-2 restoring divider
// Divides the 64-bit total by the sample count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsa_divider #(
    parameter int COUNT_WIDTH = dsa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dsa_pkg::STAT_WIDTH-1:0] i_dividend,
    input  logic [COUNT_WIDTH-1:0]         i_divisor,
    output logic                           o_done,
    output logic [dsa_pkg::STAT_WIDTH-1:0] o_quotient
);

    logic                           r_busy;
    logic [dsa_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [COUNT_WIDTH-1:0]         r_den;
    logic [COUNT_WIDTH-1:0]         r_rem;
    logic [dsa_pkg::STAT_WIDTH-1:0] r_quo;

    logic [COUNT_WIDTH:0]           w_shift;
    logic [COUNT_WIDTH:0]           w_den_ext;
    logic [COUNT_WIDTH:0]           w_sub;
    logic                           w_ge;

    // Shift in next dividend bit and trial-subtract the divisor
    assign w_shift   = {r_rem, r_quo[dsa_pkg::STAT_WIDTH-1]};
    assign w_den_ext = {1'b0, r_den};
    assign w_ge      = (w_shift >= w_den_ext);
    assign w_sub     = w_shift - w_den_ext;

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= dsa_pkg::DIV_CNT_W'(dsa_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - dsa_pkg::DIV_CNT_W'(1);
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[COUNT_WIDTH-1:0] : w_shift[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[dsa_pkg::STAT_WIDTH-2:0], w_ge};
        end
    end

endmodule

### rtl/dsa_datapath.sv
// ----------------------------------------------------------------------------
// dsa_datapath: statistics registers, divider and output register
// Updates count, total, minimum, maximum and last value, and forms result words.
// ----------------------------------------------------------------------------
module dsa_datapath #(
    parameter int TICK_WIDTH  = dsa_pkg::TICK_WIDTH_DEF,
    parameter int COUNT_WIDTH = dsa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_wdata,
    input  logic                           i_command,
    input  logic [TICK_WIDTH-1:0]          i_duration,
    input  dsa_pkg::t_ctrl_cmd             i_cmd,
    output dsa_pkg::t_dp_status            o_status,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [dsa_pkg::STAT_WIDTH-1:0] o_selected_stat,
    output logic [TICK_WIDTH-1:0]          o_last_duration,
    output logic [COUNT_WIDTH-1:0]         o_sample_count,
    output logic                           o_no_samples
);

    localparam int SW = dsa_pkg::STAT_WIDTH;

    dsa_pkg::t_stat_mode   r_stat_mode;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [SW-1:0]          r_total;
    logic [TICK_WIDTH-1:0]  r_min;
    logic [TICK_WIDTH-1:0]  r_max;
    logic [TICK_WIDTH-1:0]  r_last;

    logic                   r_out_valid;
    logic [SW-1:0]          r_out_stat;
    logic [TICK_WIDTH-1:0]  r_out_last;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic                   r_out_empty;

    logic [SW:0]            w_dur_ext;
    logic [SW:0]            w_sum;
    logic [SW:0]            w_min_ext;
    logic [SW:0]            w_max_ext;
    logic [SW-1:0]          w_stat;
    logic                   w_div_done;
    logic [SW-1:0]          w_quotient;

    // Widen duration for the saturating add
    assign w_dur_ext = {{(SW + 1 - TICK_WIDTH){1'b0}}, i_duration};
    assign w_sum     = {1'b0, r_total} + w_dur_ext;
    assign w_min_ext = {{(SW + 1 - TICK_WIDTH){1'b0}}, r_min};
    assign w_max_ext = {{(SW + 1 - TICK_WIDTH){1'b0}}, r_max};

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_mode <= dsa_pkg::STAT_SUM;
        end else if (i_cfg_we) begin
            r_stat_mode <= dsa_pkg::t_stat_mode'(i_cfg_wdata);
        end
    end

    // Statistics update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_last  <= '0;
        end else if (i_cmd.accept) begin
            if (i_command == dsa_pkg::CMD_CLEAR) begin
                r_count <= '0;
                r_total <= '0;
                r_min   <= '1;
                r_max   <= '0;
                r_last  <= '0;
            end else begin
                r_last <= i_duration;
                if (r_count != '1) begin
                    r_count <= r_count + COUNT_WIDTH'(1);
                end
                r_total <= w_sum[SW] ? '1 : w_sum[SW-1:0];
                if (r_min > i_duration) begin
                    r_min <= i_duration;
                end
                if (r_max < i_duration) begin
                    r_max <= i_duration;
                end
            end
        end
    end

    // Average divider
    dsa_divider #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_total),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Select the reported statistic
    always_comb begin
        case (r_stat_mode)
            dsa_pkg::STAT_SUM: w_stat = r_total;
            dsa_pkg::STAT_MIN: w_stat = w_min_ext[SW-1:0];
            dsa_pkg::STAT_MAX: w_stat = w_max_ext[SW-1:0];
            dsa_pkg::STAT_AVG: w_stat = (r_count == '0) ? '0 : w_quotient;
            default:           w_stat = r_total;
        endcase
    end

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_stat  <= w_stat;
            r_out_last  <= r_last;
            r_out_count <= r_count;
            r_out_empty <= (r_count == '0);
        end
    end

    assign o_status.div_needed = (r_stat_mode == dsa_pkg::STAT_AVG) && (r_count != '0);
    assign o_status.div_done   = w_div_done;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_selected_stat = r_out_stat;
    assign o_last_duration = r_out_last;
    assign o_sample_count  = r_out_count;
    assign o_no_samples    = r_out_empty;

endmodule

### rtl/dsa_ctrl.sv
// ----------------------------------------------------------------------------
// dsa_ctrl: sequencing controller
// Takes one input word, runs the divider when needed and loads the result.
// ----------------------------------------------------------------------------
module dsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dsa_pkg::t_dp_status i_status,
    output dsa_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CALC  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_CALC;
                end
            end
            ST_CALC: begin
                if (i_status.div_needed) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/duration_statistics_accumulator.sv
// ----------------------------------------------------------------------------
// duration_statistics_accumulator: running duration statistics
// Keeps count, total, minimum, maximum and last duration, and reports the
// statistic selected by the mode register with every word.
//
//   Channel   Dir  Handshake       Payload
//   i_in      in   valid / ready   command, duration_ticks
//   o_out     out  valid / ready   selected_stat, last_duration,
//                                  sample_count, no_samples
//   i_cfg_*   in   write enable    stat_mode (2 bits)
//
// Each accepted word passes CALC, then WRITE, which loads the result word once
// the output register is free. In average mode with a nonzero count the
// radix-2 divider runs in DIV between CALC and WRITE, one quotient bit per
// step. A new word is taken only in IDLE, after the last result is loaded.
// Reset is synchronous and active low; it clears the statistics and the mode.
// A stalled result sits in the output register while the next word is taken;
// that word's result waits until the register is free.
// ----------------------------------------------------------------------------
module duration_statistics_accumulator #(
    parameter int TICK_WIDTH  = dsa_pkg::TICK_WIDTH_DEF,
    parameter int COUNT_WIDTH = dsa_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    dsa_in_if.sink     i_in,
    dsa_out_if.source  o_out
);

    dsa_pkg::t_ctrl_cmd  w_cmd;
    dsa_pkg::t_dp_status w_status;

    // Sequencing controller
    dsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Statistics datapath
    dsa_datapath #(
        .TICK_WIDTH  (TICK_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_in.command),
        .i_duration      (i_in.duration_ticks),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_selected_stat (o_out.selected_stat),
        .o_last_duration (o_out.last_duration),
        .o_sample_count  (o_out.sample_count),
        .o_no_samples    (o_out.no_samples)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for duration_statistics_accumulator
// Sends record and clear words through the input channel under random sender
// gaps and receiver stalls. A local copy of the count, total, minimum, maximum
// and last duration predicts every result word, and each result is checked
// field by field in order. Runs cover all four statistic modes, empty
// statistics and runs of maximum durations.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TICK_W      = dsa_pkg::TICK_WIDTH_DEF;
    localparam int COUNT_W     = dsa_pkg::COUNT_WIDTH_DEF;
    localparam int SW          = dsa_pkg::STAT_WIDTH;
    localparam int MAX_REPORTS = 10;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_PAUSE = 8;
    localparam int END_PAUSE   = 100;
    localparam int MAX_RECORDS = 6;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 230;

    typedef struct packed {
        logic [SW-1:0]      stat;
        logic [TICK_W-1:0]  last;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } t_stats_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    dsa_in_if  #(.TICK_WIDTH(TICK_W)) in_if ();
    dsa_out_if #(.TICK_WIDTH(TICK_W), .COUNT_WIDTH(COUNT_W)) out_if ();

    duration_statistics_accumulator #(
        .TICK_WIDTH  (TICK_W),
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predicted statistics and the words still owed by the block
    logic [COUNT_W-1:0]  acc_count;
    logic [SW-1:0]       acc_total;
    logic [TICK_W-1:0]   acc_min;
    logic [TICK_W-1:0]   acc_max;
    logic [TICK_W-1:0]   acc_last;
    dsa_pkg::t_stat_mode acc_mode;
    t_stats_word         expected_words[$];

    bit idle_on   = 1'b1;
    int rx_stall  = 0;
    int fail_count = 0;
    int n_records  = 0;
    int n_clears   = 0;
    int n_checked  = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Restore the predicted statistics to their cleared values
    function automatic void clear_stats_model();
        acc_count = '0;
        acc_total = '0;
        acc_min   = '1;
        acc_max   = '0;
        acc_last  = '0;
    endfunction

    // Update the predicted statistics with one accepted word and queue its result
    function automatic void accumulate_word(input logic cmd, input logic [TICK_W-1:0] dur);
        logic [SW:0] wide_sum;
        t_stats_word w;
        if (cmd == dsa_pkg::CMD_CLEAR) begin
            clear_stats_model();
        end else begin
            wide_sum = {1'b0, acc_total} + (SW + 1)'(dur);
            acc_last = dur;
            if (acc_count != '1) acc_count = acc_count + COUNT_W'(1);
            acc_total = wide_sum[SW] ? '1 : wide_sum[SW-1:0];
            if (dur < acc_min) acc_min = dur;
            if (dur > acc_max) acc_max = dur;
        end
        case (acc_mode)
            dsa_pkg::STAT_SUM: w.stat = acc_total;
            dsa_pkg::STAT_MIN: w.stat = SW'(acc_min);
            dsa_pkg::STAT_MAX: w.stat = SW'(acc_max);
            default:  w.stat = (acc_count != '0) ? acc_total / SW'(acc_count) : '0;
        endcase
        w.last  = acc_last;
        w.count = acc_count;
        w.empty = (acc_count == '0);
        expected_words.push_back(w);
    endfunction

    // Send one word: optional gap, then hold valid until it is taken
    task automatic send_word(input logic cmd, input logic [TICK_W-1:0] dur);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.command        <= cmd;
        in_if.duration_ticks <= dur;
        do @(posedge i_clk); while (!in_if.ready);
        accumulate_word(cmd, dur);
        if (cmd == dsa_pkg::CMD_CLEAR) n_clears++;
        else n_records++;
    endtask

    // Drop valid and wait until every owed word has come back
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // Change the statistic mode while the block is idle
    task automatic write_mode(input dsa_pkg::t_stat_mode mode);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        acc_mode = mode;
    endtask

    // Reset mode is sum; cleared and extreme durations
    task automatic test_reset_defaults();
        send_word(dsa_pkg::CMD_CLEAR, '0);
        send_word(dsa_pkg::CMD_RECORD, '0);
        send_word(dsa_pkg::CMD_RECORD, '1);
        send_word(dsa_pkg::CMD_RECORD, TICK_W'(17));
    endtask

    // Minimum, maximum and average statistics on empty, extreme and mid-range samples
    task automatic test_each_mode();
        dsa_pkg::t_stat_mode modes[3];
        modes = '{dsa_pkg::STAT_MIN, dsa_pkg::STAT_MAX, dsa_pkg::STAT_AVG};
        foreach (modes[i]) begin
            write_mode(modes[i]);
            send_word(dsa_pkg::CMD_CLEAR, '1);
            send_word(dsa_pkg::CMD_RECORD, '1);
            send_word(dsa_pkg::CMD_RECORD, '0);
            send_word(dsa_pkg::CMD_RECORD, TICK_W'(12345));
        end
    endtask

    // Back-to-back maximum durations, then average and maximum on the large total.
    // Total and count saturation need 2^16 and 2^32 samples and are out of reach here.
    task automatic test_max_durations();
        write_mode(dsa_pkg::STAT_SUM);
        idle_on = 1'b0;
        send_word(dsa_pkg::CMD_CLEAR, '0);
        repeat (MAX_RECORDS) send_word(dsa_pkg::CMD_RECORD, '1);
        send_word(dsa_pkg::CMD_RECORD, '0);
        write_mode(dsa_pkg::STAT_AVG);
        send_word(dsa_pkg::CMD_RECORD, TICK_W'(3));
        send_word(dsa_pkg::CMD_RECORD, '1);
        write_mode(dsa_pkg::STAT_MAX);
        send_word(dsa_pkg::CMD_RECORD, '0);
        idle_on = 1'b1;
        send_word(dsa_pkg::CMD_CLEAR, '0);
    endtask

    // Random records and clears, one mode per phase
    task automatic test_random_phases();
        dsa_pkg::t_stat_mode phase_modes[PHASES];
        logic [63:0]         r;
        logic [TICK_W-1:0]   dur;
        logic                cmd;
        int                  stretch;
        phase_modes[0] = dsa_pkg::STAT_AVG;
        phase_modes[1] = dsa_pkg::STAT_SUM;
        phase_modes[2] = dsa_pkg::STAT_MIN;
        phase_modes[3] = dsa_pkg::STAT_MAX;
        for (int p = 4; p < PHASES; p++)
            phase_modes[p] = dsa_pkg::t_stat_mode'($urandom_range(0, 3));
        stretch = 0;
        for (int p = 0; p < PHASES; p++) begin
            write_mode(phase_modes[p]);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // switch between idling and full-rate stretches
                if (stretch == 0) begin
                    stretch = $urandom_range(20, 60);
                    idle_on = ($urandom_range(0, 3) != 0);
                end
                stretch--;
                r = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0:       dur = '0;
                    1:       dur = '1;
                    2:       dur = '1 - TICK_W'($urandom_range(0, 255));
                    3, 4:    dur = TICK_W'($urandom_range(0, 1000));
                    default: dur = r[TICK_W-1:0];
                endcase
                cmd = ($urandom_range(0, 99) < 5) ? dsa_pkg::CMD_CLEAR : dsa_pkg::CMD_RECORD;
                send_word(cmd, dur);
            end
        end
        idle_on = 1'b1;
    endtask

    // Receiver: hold ready low for the drawn stall, then raise it
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_stall > 0) begin
                out_if.ready <= 1'b0;
                rx_stall--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_stats_word got;
        t_stats_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.selected_stat, out_if.last_duration,
                   out_if.sample_count, out_if.no_samples};
            rx_stall = idle_on ? $urandom_range(0, 11) : 0;
            n_checked++;
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: unexpected word stat=%h last=%h count=%0d empty=%b",
                             got.stat, got.last, got.count, got.empty);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("ERROR: word %0d exp stat=%h last=%h count=%0d empty=%b",
                                 n_checked, want.stat, want.last, want.count, want.empty);
                        $display("       got stat=%h last=%h count=%0d empty=%b",
                                 got.stat, got.last, got.count, got.empty);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("ERROR: no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL duration_statistics_accumulator");
        $finish;
    end

    // Main sequence
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        in_if.valid          = 1'b0;
        in_if.command        = dsa_pkg::CMD_RECORD;
        in_if.duration_ticks = '0;
        clear_stats_model();
        acc_mode = dsa_pkg::STAT_SUM;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_each_mode();
        test_max_durations();
        test_random_phases();

        wait_drained();
        repeat (END_PAUSE) @(posedge i_clk);
        $display("Covered %0d records and %0d clears over all four statistic modes.",
                 n_records, n_clears);
        $display("Checked %0d result words against the predicted statistics.", n_checked);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("PASS duration_statistics_accumulator");
        end else begin
            $display("FAIL duration_statistics_accumulator");
        end
        $finish;
    end

endmodule
